### rtl/pts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// shared types and constants of the priority task scheduler
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int DELAY_W = 16;

  // operation codes carried on the input tuser
  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_DELAY  = 2'd1,
    OP_TICK   = 2'd2,
    OP_YIELD  = 2'd3
  } op_t;

  // per-slot task state
  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_READY = 2'd1,
    SLOT_SLEEP = 2'd2
  } slot_state_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_APPLY  = 2'd1,
    ST_WALK   = 2'd2,
    ST_FINISH = 2'd3
  } fsm_t;

  // strobes from the sequencer to the datapath
  typedef struct packed {
    logic accept;
    logic apply;
    logic walk;
    logic finish;
  } ctrl_t;

endpackage

### rtl/pts_slot_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_slot_alu
// shared slot unit: tick decrement, wake check and ready detect for one slot
// ----------------------------------------------------------------------------
module pts_slot_alu (
  input  pts_pkg::slot_state_t               st_in,
  input  logic [pts_pkg::DELAY_W-1:0]        dly_in,
  input  logic                               do_tick,
  output pts_pkg::slot_state_t               st_out,
  output logic [pts_pkg::DELAY_W-1:0]        dly_out,
  output logic                               ready
);
  import pts_pkg::*;

  always_comb begin
    st_out  = st_in;
    dly_out = dly_in;
    if (do_tick && st_in == SLOT_SLEEP) begin
      if (dly_in != '0) begin
        dly_out = dly_in - DELAY_W'(1);
      end
      if (dly_out == '0) begin
        st_out = SLOT_READY;
      end
    end
    ready = (st_out == SLOT_READY);
  end

endmodule

### rtl/pts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_ctrl
// sequencer: accept, apply the operation, walk the slots, deliver the word
// ----------------------------------------------------------------------------
module pts_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic           need_walk,
  input  logic           walk_last,
  input  logic           out_free,
  output logic           s_tready,
  output pts_pkg::ctrl_t ctrl
);
  import pts_pkg::*;

  fsm_t state;
  fsm_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        state_next = need_walk ? ST_WALK : ST_FINISH;
      end
      ST_WALK: begin
        if (walk_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = (state == ST_IDLE);
    ctrl.accept = (state == ST_IDLE) && s_tvalid;
    ctrl.apply  = (state == ST_APPLY);
    ctrl.walk   = (state == ST_WALK);
    ctrl.finish = (state == ST_FINISH) && out_free;
  end

endmodule

### rtl/priority_task_scheduler_with_delays.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_task_scheduler_with_delays
// fixed-priority scheduler with per-slot tick delays and an idle slot
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tuser op, tdata task_slot + delay_amount
//  m_*      out  m_tvalid/m_tready    tdata running_task, flags, tick_count
//  cfg_*    in   cfg_valid/cfg_ready  cfg_data = yield_enable
//
//  create, refused delay and ignored yield go from apply straight to the
//    result; delay, tick and accepted yield first walk the slot file
//    through the one shared slot unit, one slot a cycle
//  a new word is taken only once the last result sits in the output
//    register; a stalled output holds the sequencer
//  synchronous reset: all slots empty, idle slot running, tick count zero
// ----------------------------------------------------------------------------
module priority_task_scheduler_with_delays #(
  parameter int NUM_TASKS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // [1:0] op
  input  logic [23:0] s_tdata,   // [2:0] task_slot, [18:3] delay_amount, rest zero
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [3:0] running_task, [4] switched,
                                 // [5] create_rejected, [37:6] tick_count
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import pts_pkg::*;

  // slot index width and width that also holds the idle index
  localparam int IDX_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int SLOT_W = $clog2(NUM_TASKS + 1);
  localparam logic [SLOT_W-1:0] IDLE_SLOT = SLOT_W'(NUM_TASKS);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_TASKS - 1);

  ctrl_t ctrl;
  logic  need_walk;
  logic  walk_last;
  logic  out_free;

  // configuration register
  logic yield_enable;

  // latched word
  op_t                op_q;
  logic [2:0]         slot_q;
  logic [DELAY_W-1:0] amount_q;

  // scheduler state; the idle slot is always ready and is not stored
  slot_state_t        slot_st  [NUM_TASKS];
  logic [DELAY_W-1:0] slot_dly [NUM_TASKS];
  logic [SLOT_W-1:0]  running;
  logic [31:0]        tick_counter;

  // walk bookkeeping
  logic [IDX_W-1:0] idx;
  logic             found_valid;
  logic [IDX_W-1:0] found_idx;
  logic             walked;
  logic             rejected;

  // shared unit wires
  slot_state_t        alu_st;
  logic [DELAY_W-1:0] alu_dly;
  logic               alu_ready;
  logic               do_tick;

  logic              create_ok;
  logic              running_busy;
  logic [SLOT_W-1:0] running_next;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign walk_last = (idx == LAST_IDX);
  assign do_tick   = (op_q == OP_TICK);

  // create is refused for the idle slot and anything past it
  assign create_ok    = (32'(slot_q) < NUM_TASKS);
  assign running_busy = (running != IDLE_SLOT);

  // which ops reschedule
  always_comb begin
    unique case (op_q)
      OP_CREATE: need_walk = 1'b0;
      OP_DELAY:  need_walk = running_busy;
      OP_TICK:   need_walk = 1'b1;
      OP_YIELD:  need_walk = yield_enable;
      default:   need_walk = 1'b0;
    endcase
  end

  pts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .need_walk (need_walk),
    .walk_last (walk_last),
    .out_free  (out_free),
    .s_tready  (s_tready),
    .ctrl      (ctrl)
  );

  pts_slot_alu u_alu (
    .st_in   (slot_st[idx]),
    .dly_in  (slot_dly[idx]),
    .do_tick (do_tick),
    .st_out  (alu_st),
    .dly_out (alu_dly),
    .ready   (alu_ready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      yield_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      yield_enable <= cfg_data;
    end
  end

  // word capture
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      op_q     <= op_t'(s_tuser);
      slot_q   <= s_tdata[2:0];
      amount_q <= s_tdata[18:3];
    end
  end

  // slot states: create, delay and the tick write-back of the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        slot_st[i] <= SLOT_EMPTY;
      end
    end else begin
      if (ctrl.apply && op_q == OP_CREATE && create_ok) begin
        slot_st[IDX_W'(slot_q)] <= SLOT_READY;
      end
      if (ctrl.apply && op_q == OP_DELAY && running_busy) begin
        slot_st[IDX_W'(running)] <= SLOT_SLEEP;
      end
      if (ctrl.walk && do_tick) begin
        slot_st[idx] <= alu_st;
      end
    end
  end

  // delay counters are written in the same cycle that a slot is put to sleep
  always_ff @(posedge clk) begin
    if (ctrl.apply && op_q == OP_DELAY && running_busy) begin
      slot_dly[IDX_W'(running)] <= amount_q;
    end
    if (ctrl.walk && do_tick) begin
      slot_dly[idx] <= alu_dly;
    end
  end

  // walk index and first ready slot
  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      found_valid <= 1'b0;
      walked      <= 1'b0;
      rejected    <= 1'b0;
    end else begin
      if (ctrl.accept) begin
        idx         <= '0;
        found_valid <= 1'b0;
      end
      if (ctrl.apply) begin
        walked   <= need_walk;
        rejected <= (op_q == OP_CREATE) && !create_ok;
      end
      if (ctrl.walk) begin
        if (!walk_last) idx <= idx + IDX_W'(1);
        if (alu_ready && !found_valid) begin
          found_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.walk && alu_ready && !found_valid) begin
      found_idx <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= '0;
    end else if (ctrl.apply && op_q == OP_TICK) begin
      tick_counter <= tick_counter + 32'd1;
    end
  end

  // lowest ready slot wins, else the idle slot; without a walk the running slot stays
  always_comb begin
    if (!walked) begin
      running_next = running;
    end else if (found_valid) begin
      running_next = SLOT_W'(found_idx);
    end else begin
      running_next = IDLE_SLOT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= IDLE_SLOT;
    end else if (ctrl.finish) begin
      running <= running_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      m_tdata[3:0]   <= 4'(running_next);
      m_tdata[4]     <= (running_next != running);
      m_tdata[5]     <= rejected;
      m_tdata[37:6]  <= tick_counter;
      m_tdata[39:38] <= 2'b00;
    end
  end

`ifndef SYNTHESIS
  a_accept_apply: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> ctrl.apply)
    else $error("accepted word not applied in the next cycle");

  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.walk |-> (32'(idx) < NUM_TASKS))
    else $error("slot walk ran past the last slot");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[4] && m_tdata[5]))
    else $error("rejected create reported a switch");

  a_runs_ready: assert property (@(posedge clk) disable iff (rst)
    (ctrl.finish && walked) |=>
      (running == IDLE_SLOT || slot_st[IDX_W'(running)] == SLOT_READY))
    else $error("scheduled slot is not ready");

  a_finish_frees: assert property (@(posedge clk) disable iff (rst)
    ctrl.finish |=> (m_tvalid && s_tready))
    else $error("result not loaded or sequencer not back to idle");
`endif

endmodule
